// File: hdl/cjdq_pkg.sv
package cjdq_pkg;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_DISPATCH = 3'd1,
		OP_CONCLUDE = 3'd2,
		OP_RETRY    = 3'd3,
		OP_ADD_MT   = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	localparam logic [2:0] ACT_ADDF   = 3'd0;
	localparam logic [2:0] ACT_ADDD   = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_DELETE = 3'd3;
	localparam logic [2:0] ACT_CANCEL = 3'd4;
	localparam logic [2:0] ACT_TERM   = 3'd5;
	localparam logic [2:0] MERGE_BAD  = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_CONFLICT = 3'd2;
	localparam logic [2:0] ST_NOKEY    = 3'd3;
	localparam logic [2:0] ST_NONE     = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] path_key;
		logic [2:0]  action;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_key;
		logic [2:0]  out_action;
	} out_item_t;

	// Combine an older action with a newer one for the same key.
	function automatic logic [2:0] merge(input logic [2:0] o, input logic [2:0] n);
		logic o_add;
		logic n_add;
		o_add = (o == ACT_ADDF) || (o == ACT_ADDD);
		n_add = (n == ACT_ADDF) || (n == ACT_ADDD);
		if (o == ACT_CANCEL) merge = n;
		else if (n == ACT_CANCEL) merge = ACT_CANCEL;
		else if (o == n && (o == ACT_UPDATE || o == ACT_DELETE)) merge = o;
		else if (n == ACT_DELETE) merge = (o == ACT_UPDATE) ? ACT_DELETE : ACT_CANCEL;
		else if ((o_add && n_add) || (o == ACT_DELETE && n == ACT_UPDATE) ||
				(o == ACT_UPDATE)) merge = MERGE_BAD;
		else if (o_add) merge = o;
		else merge = ACT_UPDATE;
	endfunction

endpackage

// File: hdl/coalescing_job_dispatch_queue.sv
// Channel | Direction | Handshake         | Payload
// in      | into      | in_valid/in_stall | cjdq_pkg::in_item_t
// out     | out of    | out_valid/out_stall | cjdq_pkg::out_item_t
// A sequencer walks the lists one entry per cycle, comparing keys at each step.
// Add walks the pending list and conclude the in-flight slots before offering a result,
// a removal adds a shift of the later pending entries, and retry walks both lists.
// Dispatch scans every in-flight slot per candidate.
// Reset clears counts and valid bits; stores are undefined until written.
// in_stall is high from acceptance until the result is taken downstream.
module coalescing_job_dispatch_queue #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cjdq_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output cjdq_pkg::out_item_t out_item
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_FINDP  = 9'b000000010,
		S_FINDF  = 9'b000000100,
		S_DECIDE = 9'b000001000,
		S_DCAND  = 9'b000010000,
		S_DSCAN  = 9'b000100000,
		S_SHIFT  = 9'b001000000,
		S_DONE   = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [KEY_BITS-1:0] pkey_q [CAPACITY];
	logic [2:0]          pact_q [CAPACITY];
	logic [KEY_BITS-1:0] fkey_q [CAPACITY];
	logic [2:0]          fact_q [CAPACITY];
	logic [CAPACITY-1:0] fvalid_q;
	logic [CW-1:0]       pcount_q;
	logic [CW-1:0]       fcount_q;

	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [2:0]          act_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       sidx_q;
	logic                pfound_q;
	logic [IW-1:0]       ppos_q;
	logic                ffound_q;
	logic [IW-1:0]       fpos_q;
	logic                fhit_q;
	logic [IW-1:0]       free_q;
	logic                freeok_q;
	logic [2:0]          st_q;
	logic [31:0]         okey_q;
	logic [2:0]          oact_q;

	logic [IW-1:0] i_idx;
	logic [IW-1:0] s_idx;
	logic [KEY_BITS-1:0] in_key;
	logic [2:0] mrg;

	assign i_idx  = idx_q[IW-1:0];
	assign s_idx  = sidx_q[IW-1:0];
	assign in_key = KEY_BITS'(in_item.path_key);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_item  = '{status: st_q, out_key: okey_q, out_action: oact_q};

	// Shared merge unit: retry merges with the in-flight action as the old one.
	always_comb begin
		if (op_q == cjdq_pkg::OP_RETRY) mrg = cjdq_pkg::merge(fact_q[fpos_q], pact_q[ppos_q]);
		else mrg = cjdq_pkg::merge(pact_q[ppos_q], act_q);
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pcount_q <= '0;
			fcount_q <= '0;
			fvalid_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_item.operation;
						key_q    <= in_key;
						act_q    <= in_item.action;
						idx_q    <= '0;
						sidx_q   <= '0;
						pfound_q <= 1'b0;
						ffound_q <= 1'b0;
						st_q     <= cjdq_pkg::ST_OK;
						okey_q   <= '0;
						oact_q   <= '0;
						case (in_item.operation)
							cjdq_pkg::OP_ADD, cjdq_pkg::OP_ADD_MT: begin
								if (in_item.action > cjdq_pkg::ACT_CANCEL) begin
									st_q    <= cjdq_pkg::ST_CONFLICT;
									state_q <= S_OUT;
								end else if (in_item.operation == cjdq_pkg::OP_ADD) begin
									state_q <= S_FINDP;
								end else begin
									state_q <= S_DECIDE;
								end
							end
							cjdq_pkg::OP_DISPATCH: state_q <= S_DCAND;
							cjdq_pkg::OP_CONCLUDE, cjdq_pkg::OP_RETRY: state_q <= S_FINDF;
							cjdq_pkg::OP_CLEAR: begin
								fvalid_q  <= '0;
								fcount_q  <= '0;
								pkey_q[0] <= '0;
								pact_q[0] <= cjdq_pkg::ACT_TERM;
								pcount_q  <= CW'(1);
								state_q   <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				// Walk in-flight slots for the item key.
				S_FINDF: begin
					if (fvalid_q[i_idx] && fkey_q[i_idx] == key_q && !ffound_q) begin
						ffound_q <= 1'b1;
						fpos_q   <= i_idx;
					end
					if (idx_q == CW'(CAPACITY - 1)) begin
						idx_q <= '0;
						if (op_q == cjdq_pkg::OP_CONCLUDE) state_q <= S_DECIDE;
						else state_q <= S_FINDP;
					end else idx_q <= idx_q + 1'b1;
				end
				// Walk pending entries for the item key.
				S_FINDP: begin
					if (idx_q < pcount_q && !pfound_q && pact_q[i_idx] != cjdq_pkg::ACT_TERM &&
							pkey_q[i_idx] == key_q) begin
						pfound_q <= 1'b1;
						ppos_q   <= i_idx;
					end
					if (idx_q >= pcount_q || idx_q == CW'(CAPACITY - 1)) state_q <= S_DECIDE;
					else idx_q <= idx_q + 1'b1;
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					case (op_q)
						cjdq_pkg::OP_ADD, cjdq_pkg::OP_ADD_MT: begin
							if (op_q == cjdq_pkg::OP_ADD_MT && pcount_q != '0) begin
								st_q <= cjdq_pkg::ST_OK;
							end else if (op_q == cjdq_pkg::OP_ADD && pfound_q) begin
								if (mrg == cjdq_pkg::MERGE_BAD) st_q <= cjdq_pkg::ST_CONFLICT;
								else if (mrg == cjdq_pkg::ACT_CANCEL) begin
									idx_q   <= CW'(ppos_q);
									state_q <= S_SHIFT;
								end else pact_q[ppos_q] <= mrg;
							end else if ((CW+1)'(pcount_q) + (CW+1)'(fcount_q) >=
									(CW+1)'(CAPACITY)) begin
								st_q <= cjdq_pkg::ST_FULL;
							end else begin
								pkey_q[pcount_q[IW-1:0]] <= key_q;
								pact_q[pcount_q[IW-1:0]] <= act_q;
								pcount_q <= pcount_q + 1'b1;
							end
						end
						cjdq_pkg::OP_CONCLUDE: begin
							if (!ffound_q) st_q <= cjdq_pkg::ST_NOKEY;
							else begin
								fvalid_q[fpos_q] <= 1'b0;
								fcount_q <= fcount_q - 1'b1;
							end
						end
						cjdq_pkg::OP_RETRY: begin
							if (!ffound_q) st_q <= cjdq_pkg::ST_NOKEY;
							else if (pfound_q) begin
								if (mrg == cjdq_pkg::MERGE_BAD) st_q <= cjdq_pkg::ST_CONFLICT;
								else begin
									fvalid_q[fpos_q] <= 1'b0;
									fcount_q <= fcount_q - 1'b1;
									if (mrg == cjdq_pkg::ACT_CANCEL) begin
										idx_q   <= CW'(ppos_q);
										state_q <= S_SHIFT;
									end else pact_q[ppos_q] <= mrg;
								end
							end else begin
								// Releasing the slot frees room, so the append always fits.
								fvalid_q[fpos_q] <= 1'b0;
								fcount_q <= fcount_q - 1'b1;
								if (pcount_q >= CW'(CAPACITY)) st_q <= cjdq_pkg::ST_FULL;
								else begin
									pkey_q[pcount_q[IW-1:0]] <= key_q;
									pact_q[pcount_q[IW-1:0]] <= fact_q[fpos_q];
									pcount_q <= pcount_q + 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
				// Dispatch: look at pending entry idx_q as a candidate.
				S_DCAND: begin
					if (idx_q >= pcount_q || idx_q >= CW'(CAPACITY)) begin
						st_q    <= cjdq_pkg::ST_NONE;
						state_q <= S_OUT;
					end else if (pact_q[i_idx] == cjdq_pkg::ACT_TERM) begin
						okey_q  <= 32'(pkey_q[i_idx]);
						oact_q  <= cjdq_pkg::ACT_TERM;
						state_q <= S_SHIFT;
					end else begin
						sidx_q   <= '0;
						fhit_q   <= 1'b0;
						freeok_q <= 1'b0;
						state_q  <= S_DSCAN;
					end
				end
				// Scan in-flight slots for a key hit and the first free slot.
				S_DSCAN: begin
					if (fvalid_q[s_idx] && fkey_q[s_idx] == pkey_q[i_idx]) fhit_q <= 1'b1;
					if (!fvalid_q[s_idx] && !freeok_q) begin
						freeok_q <= 1'b1;
						free_q   <= s_idx;
					end
					if (sidx_q == CW'(CAPACITY - 1)) begin
						if (fhit_q || (fvalid_q[s_idx] && fkey_q[s_idx] == pkey_q[i_idx])) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DCAND;
						end else if (!freeok_q && fvalid_q[s_idx]) begin
							st_q    <= cjdq_pkg::ST_NONE;
							state_q <= S_OUT;
						end else begin
							fkey_q[freeok_q ? free_q : s_idx]   <= pkey_q[i_idx];
							fact_q[freeok_q ? free_q : s_idx]   <= pact_q[i_idx];
							fvalid_q[freeok_q ? free_q : s_idx] <= 1'b1;
							fcount_q <= fcount_q + 1'b1;
							okey_q   <= 32'(pkey_q[i_idx]);
							oact_q   <= pact_q[i_idx];
							state_q  <= S_SHIFT;
						end
					end else sidx_q <= sidx_q + 1'b1;
				end
				// Close the gap at idx_q, one entry per cycle.
				S_SHIFT: begin
					if (idx_q + 1'b1 < pcount_q && idx_q + 1'b1 < CW'(CAPACITY)) begin
						pkey_q[i_idx] <= pkey_q[IW'(idx_q + 1'b1)];
						pact_q[i_idx] <= pact_q[IW'(idx_q + 1'b1)];
						idx_q <= idx_q + 1'b1;
					end else begin
						pcount_q <= pcount_q - 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: tb/tb_coalescing_job_dispatch_queue.sv
module tb_coalescing_job_dispatch_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cjdq_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	cjdq_pkg::out_item_t out_item;

	coalescing_job_dispatch_queue #(.CAPACITY(CAP), .KEY_BITS(32)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the queue contents.
	logic [31:0] pend_key [CAP];
	logic [2:0]  pend_act [CAP];
	int          pend_cnt;
	logic [31:0] fly_key [CAP];
	logic [2:0]  fly_act [CAP];
	logic [CAP-1:0] fly_vld;

	cjdq_pkg::out_item_t expected_q[$];
	int errors = 0;
	logic hold_sink = 1'b0;

	// Merge an older action with a newer one for the same key.
	function automatic logic [2:0] combine_actions(logic [2:0] o, logic [2:0] n);
		logic oa, na;
		oa = (o == cjdq_pkg::ACT_ADDF) || (o == cjdq_pkg::ACT_ADDD);
		na = (n == cjdq_pkg::ACT_ADDF) || (n == cjdq_pkg::ACT_ADDD);
		if (o == cjdq_pkg::ACT_CANCEL) return n;
		if (n == cjdq_pkg::ACT_CANCEL) return cjdq_pkg::ACT_CANCEL;
		if (o == n && (o == cjdq_pkg::ACT_UPDATE || o == cjdq_pkg::ACT_DELETE)) return o;
		if (n == cjdq_pkg::ACT_DELETE)
			return (o == cjdq_pkg::ACT_UPDATE) ? cjdq_pkg::ACT_DELETE : cjdq_pkg::ACT_CANCEL;
		if ((oa && na) || (o == cjdq_pkg::ACT_DELETE && n == cjdq_pkg::ACT_UPDATE) ||
				o == cjdq_pkg::ACT_UPDATE)
			return cjdq_pkg::MERGE_BAD;
		if (oa) return o;
		return cjdq_pkg::ACT_UPDATE;
	endfunction

	function automatic int slot_of_flying(logic [31:0] k);
		for (int i = 0; i < CAP; i++)
			if (fly_vld[i] && fly_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int slot_of_pending(logic [31:0] k);
		for (int i = 0; i < pend_cnt; i++)
			if (pend_act[i] != cjdq_pkg::ACT_TERM && pend_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void drop_pending(int p);
		for (int i = p; i + 1 < pend_cnt; i++) begin
			pend_key[i] = pend_key[i+1];
			pend_act[i] = pend_act[i+1];
		end
		if (pend_cnt > 0) pend_cnt--;
	endfunction

	function automatic logic [2:0] push_pending(logic [31:0] k, logic [2:0] a);
		if (pend_cnt + $countones(fly_vld) >= CAP) return cjdq_pkg::ST_FULL;
		pend_key[pend_cnt] = k;
		pend_act[pend_cnt] = a;
		pend_cnt++;
		return cjdq_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] fold_into(int p, logic [2:0] a, bit incoming_old);
		logic [2:0] r;
		r = incoming_old ? combine_actions(a, pend_act[p]) : combine_actions(pend_act[p], a);
		if (r == cjdq_pkg::MERGE_BAD) return cjdq_pkg::ST_CONFLICT;
		if (r == cjdq_pkg::ACT_CANCEL) drop_pending(p);
		else pend_act[p] = r;
		return cjdq_pkg::ST_OK;
	endfunction

	// Work out the result of one command and update the shadow state.
	function automatic cjdq_pkg::out_item_t predict_queue(cjdq_pkg::in_item_t c);
		cjdq_pkg::out_item_t r;
		int p, f, s;
		logic [2:0] a;
		r = '0;
		case (c.operation)
			cjdq_pkg::OP_ADD: begin
				if (c.action > cjdq_pkg::ACT_CANCEL) r.status = cjdq_pkg::ST_CONFLICT;
				else begin
					p = slot_of_pending(c.path_key);
					r.status = (p >= 0) ? fold_into(p, c.action, 1'b0)
						: push_pending(c.path_key, c.action);
				end
			end
			cjdq_pkg::OP_DISPATCH: begin
				r.status = cjdq_pkg::ST_NONE;
				for (int i = 0; i < pend_cnt; i++) begin
					if (pend_act[i] == cjdq_pkg::ACT_TERM) begin
						r.out_key = pend_key[i];
						r.out_action = cjdq_pkg::ACT_TERM;
						drop_pending(i);
						r.status = cjdq_pkg::ST_OK;
						break;
					end
					if (slot_of_flying(pend_key[i]) >= 0) continue;
					s = 0;
					while (s < CAP && fly_vld[s]) s++;
					if (s >= CAP) break;
					r.out_key = pend_key[i];
					r.out_action = pend_act[i];
					fly_key[s] = pend_key[i];
					fly_act[s] = pend_act[i];
					fly_vld[s] = 1'b1;
					drop_pending(i);
					r.status = cjdq_pkg::ST_OK;
					break;
				end
			end
			cjdq_pkg::OP_CONCLUDE: begin
				f = slot_of_flying(c.path_key);
				if (f < 0) r.status = cjdq_pkg::ST_NOKEY;
				else fly_vld[f] = 1'b0;
			end
			cjdq_pkg::OP_RETRY: begin
				f = slot_of_flying(c.path_key);
				if (f < 0) r.status = cjdq_pkg::ST_NOKEY;
				else begin
					p = slot_of_pending(c.path_key);
					if (p >= 0) begin
						r.status = fold_into(p, fly_act[f], 1'b1);
						if (r.status == cjdq_pkg::ST_OK) fly_vld[f] = 1'b0;
					end else begin
						a = fly_act[f];
						fly_vld[f] = 1'b0;
						r.status = push_pending(c.path_key, a);
					end
				end
			end
			cjdq_pkg::OP_ADD_MT: begin
				if (c.action > cjdq_pkg::ACT_CANCEL) r.status = cjdq_pkg::ST_CONFLICT;
				else if (pend_cnt == 0) r.status = push_pending(c.path_key, c.action);
			end
			cjdq_pkg::OP_CLEAR: begin
				fly_vld = '0;
				pend_key[0] = '0;
				pend_act[0] = cjdq_pkg::ACT_TERM;
				pend_cnt = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	// Send one item and record its expected result at acceptance.
	// Valid stays high after acceptance; the next item or an idle gap replaces it.
	task automatic send_item(logic [2:0] op, logic [31:0] k, logic [2:0] a);
		cjdq_pkg::in_item_t c;
		int gap;
		c.operation = op;
		c.path_key = k;
		c.action = a;
		gap = ($urandom_range(0, 3) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= c;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_queue(c));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Receiver stall pattern.
	always @(posedge clk) begin
		if (hold_sink) out_stall <= ($urandom_range(0, 5) != 0);
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		cjdq_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $realtime, out_item);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_item.status !== e.status) begin
					$display("%0t status: expected %0d actual %0d", $realtime,
						e.status, out_item.status);
					errors++;
				end
				if (out_item.out_key !== e.out_key) begin
					$display("%0t out_key: expected %h actual %h", $realtime,
						e.out_key, out_item.out_key);
					errors++;
				end
				if (out_item.out_action !== e.out_action) begin
					$display("%0t out_action: expected %0d actual %0d", $realtime,
						e.out_action, out_item.out_action);
					errors++;
				end
			end
		end
	end

	// Merge table: every old and new action pair on a fresh key, then a clear and a dispatch.
	task automatic test_merges();
		logic [31:0] k;
		for (int o = 0; o <= 4; o++) begin
			for (int n = 0; n <= 4; n++) begin
				k = 32'h100 + o * 8 + n;
				send_item(cjdq_pkg::OP_ADD, k, o[2:0]);
				send_item(cjdq_pkg::OP_ADD, k, n[2:0]);
				send_item(cjdq_pkg::OP_ADD, k, cjdq_pkg::ACT_CANCEL);
				send_item(cjdq_pkg::OP_ADD, k, cjdq_pkg::ACT_CANCEL);
			end
		end
		send_item(cjdq_pkg::OP_CLEAR, '0, '0);
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
	endtask

	// Directed corners: extremes, invalid codes, terminate job, full, unknown keys.
	task automatic test_directed();
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_CONCLUDE, 32'hFFFF_FFFF, '0);
		send_item(cjdq_pkg::OP_RETRY, 32'h0, '0);
		send_item(cjdq_pkg::OP_ADD, 32'hFFFF_FFFF, cjdq_pkg::ACT_DELETE);
		send_item(cjdq_pkg::OP_ADD, 32'h0, 3'd7);
		send_item(cjdq_pkg::OP_ADD_MT, 32'h5, 3'd5);
		send_item(cjdq_pkg::OP_ADD_MT, 32'h5, cjdq_pkg::ACT_ADDD);
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_RETRY, 32'hFFFF_FFFF, '0);
		send_item(cjdq_pkg::OP_ADD, 32'h0, cjdq_pkg::ACT_UPDATE);
		send_item(3'd6, 32'hA5A5_5A5A, 3'd6);
		send_item(3'd7, 32'h5A5A_A5A5, 3'd7);
		send_item(cjdq_pkg::OP_CLEAR, 32'h1234, cjdq_pkg::ACT_ADDF);
		send_item(cjdq_pkg::OP_ADD, 32'h0, cjdq_pkg::ACT_ADDF);
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_CONCLUDE, 32'h0, '0);
		for (int i = 0; i < CAP + 2; i++) send_item(cjdq_pkg::OP_ADD, 32'(i), cjdq_pkg::ACT_ADDF);
		send_item(cjdq_pkg::OP_ADD_MT, 32'h77, cjdq_pkg::ACT_ADDF);
		for (int i = 0; i < CAP + 1; i++) send_item(cjdq_pkg::OP_DISPATCH, '0, '0);
		send_item(cjdq_pkg::OP_ADD, 32'h3, cjdq_pkg::ACT_DELETE);
		send_item(cjdq_pkg::OP_RETRY, 32'h3, '0);
		send_item(cjdq_pkg::OP_CLEAR, '0, '0);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) | $urandom_range(0, 15);
			default: return 32'h40 + $urandom_range(0, 11);
		endcase
	endfunction

	// Random traffic, mostly coherent over a small key pool.
	task automatic test_random(int count);
		int w;
		logic [2:0] op, a;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) drain_results();
			hold_sink = (i % 300) > 250;
			w = $urandom_range(0, 99);
			if (w < 35) op = cjdq_pkg::OP_ADD;
			else if (w < 60) op = cjdq_pkg::OP_DISPATCH;
			else if (w < 75) op = cjdq_pkg::OP_CONCLUDE;
			else if (w < 87) op = cjdq_pkg::OP_RETRY;
			else if (w < 95) op = cjdq_pkg::OP_ADD_MT;
			else if (w < 97) op = cjdq_pkg::OP_CLEAR;
			else op = 3'($urandom_range(6, 7));
			a = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			send_item(op, pick_key(), a);
		end
		hold_sink = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < CAP; i++) begin
			pend_key[i] = '0;
			pend_act[i] = '0;
			fly_key[i] = '0;
			fly_act[i] = '0;
		end
		pend_cnt = 0;
		fly_vld = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_merges();
		test_random(1000);
		drain_results();
		repeat (400) @(posedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
